/* hw/rtl/fifo_with_search_and_delete_macros.svh */
// Assertion macros for the queue RTL.
`ifndef FIFO_WITH_SEARCH_AND_DELETE_MACROS_SVH
`define FIFO_WITH_SEARCH_AND_DELETE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define FWSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define FWSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fwsd_pkg.sv */
// Shared types and constants for the searchable id queue.
package fwsd_pkg;

  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_ID_WIDTH    = 16;

  localparam int ID_FIELD_W  = 16;
  localparam int POS_FIELD_W = 5;
  localparam int CNT_FIELD_W = 6;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_POP    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                 mode;
    logic [ID_FIELD_W-1:0] client_id;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [ID_FIELD_W-1:0]  result_id;
    logic [POS_FIELD_W-1:0] position;
    logic [CNT_FIELD_W-1:0] entry_count;
  } out_item_t;

endpackage

/* hw/rtl/fwsd_mem.sv */
// Entry storage: one write port, one read port, registered read data.
module fwsd_mem #(
  parameter int DEPTH = fwsd_pkg::DEF_QUEUE_DEPTH,
  parameter int WIDTH = fwsd_pkg::DEF_ID_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/fwsd_ctrl.sv */
// Queue sequencer: circular head/count, serial scan, delete compaction, result register.
`include "fifo_with_search_and_delete_macros.svh"

module fwsd_ctrl #(
  parameter int DEPTH = fwsd_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_W  = fwsd_pkg::DEF_ID_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fwsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fwsd_pkg::out_item_t out_data,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [ID_W-1:0]     mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  logic [ID_W-1:0]     mem_rdata
);

  import fwsd_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             found_r, found_nxt;
  mode_t            mode_r, mode_nxt;
  logic [ID_W-1:0]  key_r, key_nxt;
  logic [ID_W-1:0]  rid_r, rid_nxt;
  out_item_t        res_r;
  out_item_t        out_r;
  logic             out_valid_r, out_valid_nxt;

  out_item_t        res;
  logic             fin;
  logic             out_free;
  logic             load_out;
  logic             last;
  logic             match;
  logic [ID_W-1:0]  in_key;

  // logical offset from head -> physical slot
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] ofs);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW+1)'(ofs);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_key   = ID_W'(in_data.client_id);
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign last     = (idx_r == (count_r - CW'(1)));
  assign match    = (mem_rdata == key_r);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r + CW'(1);
    found_nxt = found_r;
    mode_nxt  = mode_r;
    key_nxt   = key_r;
    rid_nxt   = rid_r;
    fin       = 1'b0;
    res       = '0;
    mem_we    = 1'b0;
    mem_waddr = phys(head_r, idx_r - CW'(1));
    mem_wdata = mem_rdata;
    mem_raddr = phys(head_r, idx_r + CW'(1));

    case (state_r)
      S_IDLE: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        mode_nxt  = in_data.mode;
        key_nxt   = in_key;
        mem_raddr = head_r;
        if (in_valid) begin
          if (in_data.mode == MODE_APPEND) begin
            fin = 1'b1;
            if (count_r == CW'(DEPTH)) begin
              res.status = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = phys(head_r, count_r);
              mem_wdata = in_key;
              count_nxt = count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            fin        = 1'b1;
            res.status = ST_MISS;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        case (mode_r)
          MODE_POP: begin
            fin           = 1'b1;
            res.result_id = ID_FIELD_W'(mem_rdata);
            head_nxt      = phys(head_r, CW'(1));
            count_nxt     = count_r - CW'(1);
          end
          MODE_QUERY: begin
            if (match) begin
              fin          = 1'b1;
              res.position = POS_FIELD_W'(idx_r);
            end else if (last) begin
              fin        = 1'b1;
              res.status = ST_MISS;
            end
          end
          MODE_DELETE: begin
            // after the hit, every younger entry moves one slot toward head
            mem_we = found_r;
            if (!found_r && match) begin
              found_nxt = 1'b1;
              rid_nxt   = mem_rdata;
            end
            if (last) begin
              fin = 1'b1;
              if (found_r || match) begin
                count_nxt     = count_r - CW'(1);
                res.result_id = found_r ? ID_FIELD_W'(rid_r) : ID_FIELD_W'(mem_rdata);
              end else begin
                res.status = ST_MISS;
              end
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.entry_count = CNT_FIELD_W'(count_nxt);
    if (fin) begin
      state_nxt = out_free ? S_IDLE : S_HOLD;
    end
  end

  assign load_out      = out_free && (fin || (state_r == S_HOLD));
  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    mode_r  <= mode_nxt;
    key_r   <= key_nxt;
    rid_r   <= rid_nxt;
    if (fin && !out_free) begin
      res_r <= res;
    end
    if (load_out) begin
      out_r <= (state_r == S_HOLD) ? res_r : res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `FWSD_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "entry count above depth")
  `FWSD_ASSERT_NOW(a_head_range, 1'b1, {1'b0, head_r} < (AW+1)'(DEPTH), "head pointer out of range")
  `FWSD_ASSERT_NOW(a_scan_nonempty, state_r == S_SCAN, count_r != '0, "scan on empty queue")
  `FWSD_ASSERT_NOW(a_we_owner, mem_we, (state_r == S_SCAN) || ((state_r == S_IDLE) && in_valid && (in_data.mode == MODE_APPEND)), "memory write outside append or compaction")
  `FWSD_ASSERT_NEXT(a_del_shrinks, fin && (state_r == S_SCAN) && (mode_r == MODE_DELETE) && (res.status == ST_OK), count_r == ($past(count_r) - CW'(1)), "successful delete did not shrink queue")

endmodule

/* hw/rtl/fifo_with_search_and_delete.sv */
// Top level of the bounded id queue with delete-by-id and position lookup.
// Input channel (in_valid/in_ready/in_data): one transaction per operation:
//   append, pop head, delete first match, or query first-match position.
// Result channel (out_valid/out_ready/out_data): exactly one transaction per
//   input transaction, in order, carrying status, id, position and entry count.
// Entries sit in a single-port-read synchronous RAM used as a circular buffer.
// Steps from input transaction to result valid:
//   append, full reject, empty reject: result taken straight from idle
//   pop: one RAM read of the head entry, then the result
//   query: serial scan from the head to the first hit or the last entry
//   delete: a scan over all entries (one RAM read per entry; younger
//     entries are rewritten one slot toward the head during the same pass)
// One operation is in flight at a time; in_ready is high only between
// operations, so a new transaction waits until the previous one finishes.
// A finished result waits in the output register; if that is still occupied,
// a second result is parked and in_ready stays low until the receiver takes one.
// Reset empties the queue (count and head cleared); the RAM is not cleared.
module fifo_with_search_and_delete #(
  parameter int QUEUE_DEPTH = fwsd_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_WIDTH    = fwsd_pkg::DEF_ID_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fwsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fwsd_pkg::out_item_t out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ID_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [ID_WIDTH-1:0] mem_rdata;

  fwsd_ctrl #(
    .DEPTH (QUEUE_DEPTH),
    .ID_W  (ID_WIDTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  fwsd_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
